// File: sv/dotq_pkg.sv
// Shared types and constants for the deadline-ordered timeout queue.
package dotq_pkg;

   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned ID_W        = 64;
   localparam int unsigned TIME_W      = 64;
   localparam int unsigned DELAY_W     = 32;
   localparam int unsigned DATA_W      = 32;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_CHK  = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_FIRED    = 3'd4,
      ST_IDLE     = 3'd5
   } status_type;

   typedef enum logic {
      PH_IDLE = 1'b0,
      PH_EXEC = 1'b1
   } phase_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
      logic [DATA_W-1:0] data;
   } entry_type;

   // one-cycle commands broadcast to every cell
   typedef struct packed {
      logic do_insert;
      logic do_remove;
      logic do_pop;
   } cell_ctl_type;

endpackage

// File: sv/dotq_chan_if.sv
// Request and response channel interfaces of the timeout queue.
interface dotq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic signed [dotq_pkg::ID_W-1:0]    event_id;
   logic signed [dotq_pkg::DELAY_W-1:0] delay;
   logic [dotq_pkg::DATA_W-1:0]   payload;

   modport source (output valid, opcode, event_id, delay, payload, input ready);
   modport sink   (input valid, opcode, event_id, delay, payload, output ready);
endinterface

interface dotq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic signed [dotq_pkg::ID_W-1:0] fired_id;
   logic [dotq_pkg::DATA_W-1:0]   fired_data;

   modport source (output valid, status, fired_id, fired_data, input ready);
   modport sink   (input valid, status, fired_id, fired_data, output ready);
endinterface

// File: sv/dotq_cell.sv
// One slot of the sorted queue: holds an entry, compares it, shifts with neighbors.
module dotq_cell (
   input  logic                           clock,
   input  dotq_pkg::cell_ctl_type         ctl,
   input  logic                           occ,
   input  logic [dotq_pkg::ID_W-1:0]      key_id,
   input  logic [dotq_pkg::TIME_W-1:0]    cmp_time,
   input  dotq_pkg::entry_type            new_entry,
   input  dotq_pkg::entry_type            left_entry,
   input  logic                           left_lt,
   input  dotq_pkg::entry_type            right_entry,
   input  logic                           pre_in,
   output dotq_pkg::entry_type            entry,
   output logic                           lt_out,
   output logic                           pre_out
);

   dotq_pkg::entry_type entry_ff;
   dotq_pkg::entry_type entry_in;
   logic                match;

   assign match   = occ && (entry_ff.id == key_id);
   assign pre_out = pre_in | match;
   assign lt_out  = occ && ($signed(entry_ff.deadline) < $signed(cmp_time));
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.do_insert) begin
         // sorted row: lt flags run true then false, new item lands at the edge
         if (!lt_out) begin
            entry_in = left_lt ? new_entry : left_entry;
         end
      end else if (ctl.do_remove) begin
         if (pre_out) begin
            entry_in = right_entry;
         end
      end else if (ctl.do_pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: sv/deadline_ordered_timeout_queue.sv
// Deadline-ordered timeout queue: control, time base and the row of cells.
// An accepted item is registered with its deadline sum, and its response is registered
// in the execute phase, which waits while the response register is held by rsp_if.ready low.
// A new item is taken only in the idle phase, once the last one has executed; the accept
// cycle forms the deadline sum, the execute phase compares all cells in parallel and shifts the row.
// Reset: synchronous, clears entry count, time counter and handshake state.
module deadline_ordered_timeout_queue (
   input logic         clock,
   input logic         reset,
   dotq_req_if.sink    req_if,
   dotq_rsp_if.source  rsp_if
);

   localparam int unsigned DEPTH = dotq_pkg::QUEUE_DEPTH;
   localparam int unsigned CW    = dotq_pkg::CNT_W;

   dotq_pkg::phase_type   phase_ff, phase_in;
   dotq_pkg::op_type      op_ff;
   logic [dotq_pkg::ID_W-1:0]   id_ff;
   logic [dotq_pkg::DATA_W-1:0] data_ff;
   logic [dotq_pkg::TIME_W-1:0] cmp_ff, cmp_in;
   logic [dotq_pkg::TIME_W-1:0] time_ff, time_in;
   logic [CW-1:0]         count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   dotq_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [dotq_pkg::ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [dotq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  exec_go;
   logic                  any_match;
   logic                  fire;
   dotq_pkg::cell_ctl_type ctl;
   dotq_pkg::entry_type   new_entry;

   dotq_pkg::entry_type   cells [DEPTH];
   logic [DEPTH-1:0]      lt_w;
   logic [DEPTH-1:0]      pre_w;
   logic [DEPTH-1:0]      occ_w;

   assign req_if.ready = (phase_ff == dotq_pkg::PH_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign exec_go      = (phase_ff == dotq_pkg::PH_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.fired_id   = rsp_id_ff;
   assign rsp_if.fired_data = rsp_data_ff;

   assign new_entry.id       = id_ff;
   assign new_entry.deadline = cmp_ff;
   assign new_entry.data     = data_ff;

   assign any_match = pre_w[DEPTH-1];
   assign fire      = lt_w[0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         dotq_pkg::PH_IDLE: if (accept)  phase_in = dotq_pkg::PH_EXEC;
         dotq_pkg::PH_EXEC: if (exec_go) phase_in = dotq_pkg::PH_IDLE;
         default:           phase_in = dotq_pkg::PH_IDLE;
      endcase
   end

   // deadline for add, new time for tick
   always_comb begin
      if (dotq_pkg::op_type'(req_if.opcode) == dotq_pkg::OP_TICK) begin
         cmp_in = time_ff + dotq_pkg::TIME_W'(1);
      end else begin
         cmp_in = time_ff + {{(dotq_pkg::TIME_W - dotq_pkg::DELAY_W){req_if.delay[31]}},
                             req_if.delay};
      end
   end

   // execute outputs
   always_comb begin
      ctl           = '0;
      count_in      = count_ff;
      time_in       = time_ff;
      rsp_status_in = dotq_pkg::ST_OK;
      rsp_id_in     = '0;
      rsp_data_in   = '0;
      if (exec_go) begin
         unique case (op_ff)
            dotq_pkg::OP_ADD: begin
               if (any_match) begin
                  rsp_status_in = dotq_pkg::ST_DUP;
               end else if (count_ff == CW'(DEPTH)) begin
                  rsp_status_in = dotq_pkg::ST_FULL;
               end else begin
                  ctl.do_insert = 1'b1;
                  count_in      = count_ff + CW'(1);
               end
            end
            dotq_pkg::OP_DEL: begin
               if (any_match) begin
                  ctl.do_remove = 1'b1;
                  count_in      = count_ff - CW'(1);
               end else begin
                  rsp_status_in = dotq_pkg::ST_NOTFOUND;
               end
            end
            dotq_pkg::OP_CHK: begin
               rsp_status_in = any_match ? dotq_pkg::ST_OK : dotq_pkg::ST_NOTFOUND;
            end
            dotq_pkg::OP_TICK: begin
               time_in = cmp_ff;
               if (fire) begin
                  ctl.do_pop    = 1'b1;
                  count_in      = count_ff - CW'(1);
                  rsp_status_in = dotq_pkg::ST_FIRED;
                  rsp_id_in     = cells[0].id;
                  rsp_data_in   = cells[0].data;
               end else begin
                  rsp_status_in = dotq_pkg::ST_IDLE;
               end
            end
            default: rsp_status_in = dotq_pkg::ST_OK;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dotq_pkg::PH_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= dotq_pkg::op_type'(req_if.opcode);
         id_ff   <= req_if.event_id;
         data_ff <= req_if.payload;
         cmp_ff  <= cmp_in;
      end
      if (exec_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         dotq_pkg::entry_type left_e;
         dotq_pkg::entry_type right_e;
         logic                left_l;
         logic                pre_l;

         assign occ_w[gi] = (CW'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign left_e = new_entry;
            assign left_l = 1'b1;
            assign pre_l  = 1'b0;
         end else begin : g_mid
            assign left_e = cells[gi-1];
            assign left_l = lt_w[gi-1];
            assign pre_l  = pre_w[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign right_e = cells[gi];
         end else begin : g_inner
            assign right_e = cells[gi+1];
         end

         dotq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occ         (occ_w[gi]),
            .key_id      (id_ff),
            .cmp_time    (cmp_ff),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_lt     (left_l),
            .right_entry (right_e),
            .pre_in      (pre_l),
            .entry       (cells[gi]),
            .lt_out      (lt_w[gi]),
            .pre_out     (pre_w[gi])
         );
      end
   endgenerate

endmodule

// File: sim/deadline_ordered_timeout_queue_tb.sv
// Self-checking testbench for the deadline-ordered timeout queue.
`timescale 1ns / 100ps

module deadline_ordered_timeout_queue_tb;

   localparam int ID_POOL     = 80;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      dotq_pkg::status_type          status;
      logic [dotq_pkg::ID_W-1:0]     fired_id;
      logic [dotq_pkg::DATA_W-1:0]   fired_data;
   } reply_type;

   logic clock = 1'b0;
   logic reset;

   dotq_req_if req_if ();
   dotq_rsp_if rsp_if ();

   deadline_ordered_timeout_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #4 clock = ~clock;

   // shadow copy of the table, kept sorted by deadline
   dotq_pkg::entry_type           shadow_table[$];
   logic [dotq_pkg::TIME_W-1:0]   shadow_now = '0;
   reply_type                     awaited_replies[$];
   logic [dotq_pkg::ID_W-1:0]     id_pool[ID_POOL];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int errors         = 0;
   int n_requests     = 0;
   int n_replies      = 0;
   int n_fired        = 0;
   int n_full         = 0;
   int n_dup          = 0;
   int n_missing      = 0;
   int quiet_cycles   = 0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // applies one operation to the shadow table and returns the reply it owes
   function automatic reply_type apply_queue_op(dotq_pkg::op_type op,
                                                logic [dotq_pkg::ID_W-1:0] id,
                                                logic [dotq_pkg::DELAY_W-1:0] dly,
                                                logic [dotq_pkg::DATA_W-1:0] data);
      reply_type           r;
      dotq_pkg::entry_type e;
      int                  pos;
      r.status     = dotq_pkg::ST_OK;
      r.fired_id   = '0;
      r.fired_data = '0;
      pos = -1;
      foreach (shadow_table[i])
         if (pos < 0 && shadow_table[i].id == id) pos = i;
      case (op)
         dotq_pkg::OP_ADD: begin
            if (pos >= 0)
               r.status = dotq_pkg::ST_DUP;
            else if (shadow_table.size() >= dotq_pkg::QUEUE_DEPTH)
               r.status = dotq_pkg::ST_FULL;
            else begin
               e.id       = id;
               e.deadline = shadow_now +
                            {{(dotq_pkg::TIME_W-dotq_pkg::DELAY_W){dly[dotq_pkg::DELAY_W-1]}},
                             dly};
               e.data     = data;
               pos = 0;
               // among equal deadlines the newest item goes first
               while (pos < shadow_table.size() &&
                      $signed(shadow_table[pos].deadline) < $signed(e.deadline))
                  pos++;
               shadow_table.insert(pos, e);
            end
         end
         dotq_pkg::OP_DEL: begin
            if (pos >= 0) shadow_table.delete(pos);
            else r.status = dotq_pkg::ST_NOTFOUND;
         end
         dotq_pkg::OP_CHK: begin
            if (pos < 0) r.status = dotq_pkg::ST_NOTFOUND;
         end
         default: begin
            shadow_now = shadow_now + 1;
            if (shadow_table.size() > 0 &&
                $signed(shadow_table[0].deadline) < $signed(shadow_now)) begin
               r.status     = dotq_pkg::ST_FIRED;
               r.fired_id   = shadow_table[0].id;
               r.fired_data = shadow_table[0].data;
               shadow_table.delete(0);
            end else begin
               r.status = dotq_pkg::ST_IDLE;
            end
         end
      endcase
      return r;
   endfunction

   // presents one item and returns at the edge where it is taken
   task automatic issue_op(dotq_pkg::op_type op, logic [dotq_pkg::ID_W-1:0] id,
                           logic [dotq_pkg::DELAY_W-1:0] dly,
                           logic [dotq_pkg::DATA_W-1:0] data);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.opcode   <= op;
      req_if.event_id <= id;
      req_if.delay    <= dly;
      req_if.payload  <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      awaited_replies.push_back(apply_queue_op(op, id, dly, data));
      n_requests++;
   endtask

   task automatic wait_all_replies();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
   endtask

   task automatic test_add_and_lookup();
      issue_op(dotq_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      issue_op(dotq_pkg::OP_ADD, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      issue_op(dotq_pkg::OP_ADD, 64'h0, 32'h8000_0000, 32'hA5A5_5A5A);
      issue_op(dotq_pkg::OP_CHK, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, $urandom);
      issue_op(dotq_pkg::OP_CHK, 64'h8000_0000_0000_0000, $urandom, $urandom);
      issue_op(dotq_pkg::OP_CHK, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom);
      issue_op(dotq_pkg::OP_DEL, 64'h0, $urandom, $urandom);
      issue_op(dotq_pkg::OP_DEL, 64'h0, $urandom, $urandom);
      issue_op(dotq_pkg::OP_CHK, 64'h0, $urandom, $urandom);
      wait_all_replies();
   endtask

   task automatic test_duplicate_id();
      issue_op(dotq_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      issue_op(dotq_pkg::OP_ADD, 64'h8000_0000_0000_0000, 32'd5, 32'h0);
      wait_all_replies();
   endtask

   task automatic test_tick_delivery();
      issue_op(dotq_pkg::OP_TICK, rand64(), $urandom, $urandom);
      issue_op(dotq_pkg::OP_TICK, rand64(), $urandom, $urandom);
      // three equal deadlines, then one that lands ahead of them
      issue_op(dotq_pkg::OP_ADD, 64'd10, 32'd1, 32'h0000_0010);
      issue_op(dotq_pkg::OP_ADD, 64'd11, 32'd1, 32'h0000_0011);
      issue_op(dotq_pkg::OP_ADD, 64'd12, 32'd1, 32'h0000_0012);
      issue_op(dotq_pkg::OP_ADD, 64'd13, 32'hFFFF_FFFF, 32'h0000_0013);
      repeat (6) issue_op(dotq_pkg::OP_TICK, rand64(), $urandom, $urandom);
      issue_op(dotq_pkg::OP_DEL, 64'h8000_0000_0000_0000, $urandom, $urandom);
      issue_op(dotq_pkg::OP_TICK, rand64(), $urandom, $urandom);
      wait_all_replies();
   endtask

   task automatic test_full_table();
      logic [dotq_pkg::ID_W-1:0] ids_left[$];
      while (shadow_table.size() < dotq_pkg::QUEUE_DEPTH)
         issue_op(dotq_pkg::OP_ADD, rand64(), $urandom_range(40), $urandom);
      issue_op(dotq_pkg::OP_ADD, rand64(), $urandom, $urandom);
      // a duplicate wins over the full refusal
      issue_op(dotq_pkg::OP_ADD, shadow_table[dotq_pkg::QUEUE_DEPTH/2].id, $urandom,
               $urandom);
      foreach (shadow_table[i]) ids_left.push_back(shadow_table[i].id);
      foreach (ids_left[i]) issue_op(dotq_pkg::OP_DEL, ids_left[i], $urandom, $urandom);
      wait_all_replies();
   endtask

   task automatic run_random_traffic(int count);
      int                        pick;
      logic [dotq_pkg::ID_W-1:0] id;
      logic [31:0]               dly;
      dotq_pkg::op_type          op;
      repeat (count) begin
         pick = $urandom_range(99);
         op = (pick < 35) ? dotq_pkg::OP_ADD :
              (pick < 50) ? dotq_pkg::OP_DEL :
              (pick < 65) ? dotq_pkg::OP_CHK : dotq_pkg::OP_TICK;
         id = ($urandom_range(99) < 95) ? id_pool[$urandom_range(ID_POOL-1)] : rand64();
         pick = $urandom_range(99);
         if (pick < 70)
            dly = $urandom_range(24) - 4;
         else if (pick < 90)
            dly = $urandom;
         else
            dly = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         issue_op(op, id, dly, $urandom);
      end
      wait_all_replies();
   endtask

   // reply checker and receiver stalls
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_replies++;
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected reply: status %0d id %h data %h", $time,
                     rsp_if.status, rsp_if.fired_id, rsp_if.fired_data);
            errors++;
         end else begin
            want = awaited_replies[0];
            awaited_replies.delete(0);
            if (rsp_if.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d", $time,
                        want.status, rsp_if.status);
               errors++;
            end
            if (rsp_if.fired_id !== want.fired_id) begin
               $display("%0t: fired_id mismatch: expected %h actual %h", $time,
                        want.fired_id, rsp_if.fired_id);
               errors++;
            end
            if (rsp_if.fired_data !== want.fired_data) begin
               $display("%0t: fired_data mismatch: expected %h actual %h", $time,
                        want.fired_data, rsp_if.fired_data);
               errors++;
            end
            case (want.status)
               dotq_pkg::ST_FIRED:    n_fired++;
               dotq_pkg::ST_FULL:     n_full++;
               dotq_pkg::ST_DUP:      n_dup++;
               dotq_pkg::ST_NOTFOUND: n_missing++;
               default: ;
            endcase
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d replies outstanding", $time,
                  QUIET_LIMIT, awaited_replies.size());
         $display("** deadline_ordered_timeout_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.opcode   = dotq_pkg::OP_ADD;
      req_if.event_id = '0;
      req_if.delay    = '0;
      req_if.payload  = '0;
      foreach (id_pool[i]) id_pool[i] = rand64();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct   = 22;
      recv_stall_pct = 71;
      test_add_and_lookup();
      test_duplicate_id();
      test_tick_delivery();
      test_full_table();
      run_random_traffic(220);

      send_gap_pct   = 71;
      recv_stall_pct = 22;
      run_random_traffic(220);

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      run_random_traffic(220);

      wait_all_replies();
      repeat (4) @(posedge clock);

      $display("Sent %0d requests, checked %0d replies under three idle mixes.",
               n_requests, n_replies);
      $display("Events fired %0d, full refusals %0d, duplicates %0d, ids not found %0d.",
               n_fired, n_full, n_dup, n_missing);
      if (errors == 0)
         $display("** deadline_ordered_timeout_queue: PASSED **");
      else
         $display("** deadline_ordered_timeout_queue: FAILED **");
      $finish;
   end

endmodule
